>>> rtl/ipsv_pkg.sv
// Package for the inverse Park / SVPWM block: Q14 constants, sector codes,
// pipeline tag types and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package ipsv_pkg;

   localparam int Q_BITS = 14;
   localparam logic signed [15:0] Q_SQRT3_2 = 16'sd14189;
   localparam logic [14:0] Q_SQRT3 = 15'd28378;
   localparam logic [13:0] Q_LIMIT = 14'd15728;
   localparam logic [15:0] PERIOD_RESET = 16'd3600;
   localparam logic CSR_PERIOD_INDEX = 1'b0;

   localparam logic [2:0] SIGN_U1 = 3'b001;
   localparam logic [2:0] SIGN_U2 = 3'b010;
   localparam logic [2:0] SIGN_U1U2 = 3'b011;
   localparam logic [2:0] SIGN_U3 = 3'b100;
   localparam logic [2:0] SIGN_U1U3 = 3'b101;
   localparam logic [2:0] SIGN_U2U3 = 3'b110;

   typedef enum logic [2:0] {
      SEC_NONE = 3'd0,
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5,
      SEC_6 = 3'd6
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic [15:0] lead;
      logic [15:0] back;
      logic limited;
   } scale_tag_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
      if (x > 32'sd32767) begin
         return 16'sh7FFF;
      end
      if (x < -32'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

   function automatic logic signed [17:0] trunc_q(input logic signed [31:0] x);
      logic signed [31:0] adj;
      adj = x + (x[31] ? 32'sd16383 : 32'sd0);
      return 18'(adj >>> Q_BITS);
   endfunction

   function automatic logic [15:0] compare_out(input logic signed [18:0] x);
      logic signed [18:0] h;
      h = x >>> 1;
      if (h <= 19'sd0) begin
         return 16'd1;
      end
      if (h > 19'sd65535) begin
         return 16'hFFFF;
      end
      return h[15:0];
   endfunction

endpackage

>>> rtl/ipsv_req_if.sv
// Request channel of the inverse Park / SVPWM block: valid/ready plus
// d/q commands, angle sine/cosine and bus voltage. No dependencies.
`timescale 1ns / 1ps
interface ipsv_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] volt_d;
   logic signed [15:0] volt_q;
   logic signed [13:0] angle_sin;
   logic signed [13:0] angle_cos;
   logic [15:0] bus_voltage;

   modport source (output valid, volt_d, volt_q, angle_sin, angle_cos, bus_voltage,
                   input ready);
   modport sink (input valid, volt_d, volt_q, angle_sin, angle_cos, bus_voltage,
                 output ready);
endinterface

>>> rtl/ipsv_rsp_if.sv
// Result channel of the inverse Park / SVPWM block: valid/ready plus
// three compare counts, sector and limit flag. No dependencies.
`timescale 1ns / 1ps
interface ipsv_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] compare_a;
   logic [15:0] compare_b;
   logic [15:0] compare_c;
   logic [2:0] sector;
   logic limited;

   modport source (output valid, compare_a, compare_b, compare_c, sector, limited,
                   input ready);
   modport sink (input valid, compare_a, compare_b, compare_c, sector, limited,
                 output ready);
endinterface

>>> rtl/ipsv_div_cell.sv
// One restoring division cell: two lanes sharing a divisor, one quotient
// bit per lane per cycle while adv is high, with a sideband tag. No dependencies.
`timescale 1ns / 1ps
module ipsv_div_cell #(
   parameter int NUM_W = 34,
   parameter int DIV_W = 16,
   parameter int TAG_W = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [DIV_W-1:0] in_div,
   input  logic [1:0][DIV_W-1:0] in_rem,
   input  logic [1:0][NUM_W-1:0] in_num,
   input  logic [1:0][NUM_W-1:0] in_quo,
   input  logic [TAG_W-1:0] in_tag,
   output logic out_valid,
   output logic [DIV_W-1:0] out_div,
   output logic [1:0][DIV_W-1:0] out_rem,
   output logic [1:0][NUM_W-1:0] out_num,
   output logic [1:0][NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   logic valid_ff;
   logic [DIV_W-1:0] div_ff;
   logic [1:0][DIV_W-1:0] rem_ff, rem_in;
   logic [1:0][NUM_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [TAG_W-1:0] tag_ff;
   logic [1:0][DIV_W:0] rem2, diff;
   logic [1:0] ge;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem2[l] = {in_rem[l], in_num[l][NUM_W-1]};
         diff[l] = rem2[l] - {1'b0, in_div};
         ge[l] = rem2[l] >= {1'b0, in_div};
         rem_in[l] = ge[l] ? diff[l][DIV_W-1:0] : rem2[l][DIV_W-1:0];
         num_in[l] = {in_num[l][NUM_W-2:0], 1'b0};
         quo_in[l] = {in_quo[l][NUM_W-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= in_div;
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_div = div_ff;
   assign out_rem = rem_ff;
   assign out_num = num_ff;
   assign out_quo = quo_ff;
   assign out_tag = tag_ff;
endmodule

>>> rtl/ipsv_div_chain.sv
// Row of division cells, one per quotient bit, for two lanes with a shared
// divisor. Depends on ipsv_div_cell.
`timescale 1ns / 1ps
module ipsv_div_chain #(
   parameter int NUM_W = 34,
   parameter int DIV_W = 16,
   parameter int TAG_W = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [DIV_W-1:0] in_div,
   input  logic [1:0][NUM_W-1:0] in_num,
   input  logic [TAG_W-1:0] in_tag,
   output logic out_valid,
   output logic [1:0][NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   logic [NUM_W:0] valid;
   logic [NUM_W:0][DIV_W-1:0] div;
   logic [NUM_W:0][1:0][DIV_W-1:0] rem;
   logic [NUM_W:0][1:0][NUM_W-1:0] num;
   logic [NUM_W:0][1:0][NUM_W-1:0] quo;
   logic [NUM_W:0][TAG_W-1:0] tag;

   assign valid[0] = in_valid;
   assign div[0] = in_div;
   assign rem[0] = '0;
   assign num[0] = in_num;
   assign quo[0] = '0;
   assign tag[0] = in_tag;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      ipsv_div_cell #(.NUM_W(NUM_W), .DIV_W(DIV_W), .TAG_W(TAG_W)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(valid[i]), .in_div(div[i]), .in_rem(rem[i]),
         .in_num(num[i]), .in_quo(quo[i]), .in_tag(tag[i]),
         .out_valid(valid[i+1]), .out_div(div[i+1]), .out_rem(rem[i+1]),
         .out_num(num[i+1]), .out_quo(quo[i+1]), .out_tag(tag[i+1])
      );
   end

   assign out_valid = valid[NUM_W];
   assign out_quo = quo[NUM_W];
   assign out_tag = tag[NUM_W];
endmodule

>>> rtl/inverse_park_svpwm.sv
// Inverse Park transform and seven-segment SVPWM compare generation.
// One request per cycle sustained while the result is not stalled.
// The pipeline holds two rows of division cells (34 and 32 cells), one bit each.
// A stalled result freezes the whole pipeline. Synchronous reset clears all
// valid bits and sets period_ff to 3600. Depends on ipsv_pkg, interfaces, chain.
`timescale 1ns / 1ps
module inverse_park_svpwm #(
   parameter int TIME_SCALE_SHIFT = 0,
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   ipsv_req_if.sink req_bus,
   ipsv_rsp_if.source rsp_bus,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int SEC_W = $bits(ipsv_pkg::sector_type);
   localparam int TAG2_W = $bits(ipsv_pkg::scale_tag_type);

   logic adv;
   logic [15:0] period_ff, limit_ff;
   logic [29:0] limit_prod;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic [15:0] bus_in, bus1_ff, bus2_ff, bus3_ff, bus4_ff, bus5_ff, bus6_ff, bus7_ff;
   logic signed [29:0] p_dc_in, p_qs_in, p_ds_in, p_qc_in;
   logic signed [29:0] p_dc_ff, p_qs_ff, p_ds_ff, p_qc_ff;
   logic signed [30:0] diff_a, diff_b;
   logic signed [15:0] alpha_ff, beta2_ff, beta3_ff, hb_ff, u1_ff;
   logic signed [30:0] m_in, m_ff;
   logic signed [31:0] x2, x3;
   logic signed [17:0] u2_ff, u3_ff, u1e, lead_s, back_s;
   logic [2:0] code;
   ipsv_pkg::sector_type sec_in, sec5_ff, sec6_ff, sec7_ff;
   logic [16:0] lu_in, bu_in, lu_ff, bu_ff;
   logic [31:0] la_ff, ba_ff;
   logic [47:0] ln_in, bn_in;
   logic [1:0][33:0] num7_ff;

   logic c1_valid;
   logic [1:0][33:0] c1_quo;
   logic [SEC_W-1:0] c1_tag;
   logic [33:0] lq_sh, bq_sh;
   logic [15:0] lead_in, back_in, lead8_ff, back8_ff;
   logic [16:0] sum_in, sum8_ff;
   logic flag_in, flag8_ff;
   ipsv_pkg::sector_type sec8_ff;

   logic [1:0][31:0] num9_ff;
   logic [16:0] div9_ff;
   ipsv_pkg::scale_tag_type tag9_ff, tag_out;
   logic [TAG2_W-1:0] tag9_vec;

   logic c2_valid;
   logic [1:0][31:0] c2_quo;
   logic [TAG2_W-1:0] c2_tag;
   logic [15:0] lead_f, back_f;
   logic signed [18:0] p_s, s_big, s_mid, s_small, ca, cb, cc;

   logic rsp_valid_ff, limited_ff;
   logic [15:0] cmp_a_ff, cmp_b_ff, cmp_c_ff;
   logic [2:0] sector_ff;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == ipsv_pkg::CSR_PERIOD_INDEX) ? {16'd0, period_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ipsv_pkg::PERIOD_RESET;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == ipsv_pkg::CSR_PERIOD_INDEX) begin
         period_ff <= pwdata[15:0];
      end
   end

   assign limit_prod = 30'(period_ff) * 30'(ipsv_pkg::Q_LIMIT);
   always_ff @(posedge clock) begin
      limit_ff <= limit_prod[29:14];
   end

   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= c1_valid;
         v9_ff <= v8_ff;
         rsp_valid_ff <= c2_valid;
      end
   end

   // rotate: products, then alpha/beta
   assign bus_in = (req_bus.bus_voltage == 16'd0) ? 16'd1 : req_bus.bus_voltage;
   assign p_dc_in = 30'(req_bus.volt_d) * 30'(req_bus.angle_cos);
   assign p_qs_in = 30'(req_bus.volt_q) * 30'(req_bus.angle_sin);
   assign p_ds_in = 30'(req_bus.volt_d) * 30'(req_bus.angle_sin);
   assign p_qc_in = 30'(req_bus.volt_q) * 30'(req_bus.angle_cos);
   assign diff_a = (31'(p_dc_ff) - 31'(p_qs_ff)) >>> ANGLE_FRAC_BITS;
   assign diff_b = (31'(p_ds_ff) + 31'(p_qc_ff)) >>> ANGLE_FRAC_BITS;

   // sector projections
   assign m_in = 31'(alpha_ff) * 31'(ipsv_pkg::Q_SQRT3_2);
   assign x2 = 32'(m_ff) - (32'(hb_ff) <<< ipsv_pkg::Q_BITS);
   assign x3 = -32'(m_ff) - (32'(hb_ff) <<< ipsv_pkg::Q_BITS);

   assign u1e = 18'(u1_ff);
   assign code = {u3_ff > 18'sd0, u2_ff > 18'sd0, u1e > 18'sd0};

   always_comb begin
      case (code)
         ipsv_pkg::SIGN_U1: begin
            sec_in = ipsv_pkg::SEC_2; lead_s = -u2_ff; back_s = -u3_ff;
         end
         ipsv_pkg::SIGN_U2: begin
            sec_in = ipsv_pkg::SEC_6; lead_s = -u3_ff; back_s = -u1e;
         end
         ipsv_pkg::SIGN_U1U2: begin
            sec_in = ipsv_pkg::SEC_1; lead_s = u2_ff; back_s = u1e;
         end
         ipsv_pkg::SIGN_U3: begin
            sec_in = ipsv_pkg::SEC_4; lead_s = -u1e; back_s = -u2_ff;
         end
         ipsv_pkg::SIGN_U1U3: begin
            sec_in = ipsv_pkg::SEC_3; lead_s = u1e; back_s = u3_ff;
         end
         ipsv_pkg::SIGN_U2U3: begin
            sec_in = ipsv_pkg::SEC_5; lead_s = u3_ff; back_s = u2_ff;
         end
         default: begin
            sec_in = ipsv_pkg::SEC_NONE; lead_s = 18'sd0; back_s = 18'sd0;
         end
      endcase
      lu_in = (lead_s > 18'sd0) ? lead_s[16:0] : 17'd0;
      bu_in = (back_s > 18'sd0) ? back_s[16:0] : 17'd0;
   end

   assign ln_in = 48'(la_ff) * 48'(period_ff);
   assign bn_in = 48'(ba_ff) * 48'(period_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         bus1_ff <= bus_in;
         p_dc_ff <= p_dc_in;
         p_qs_ff <= p_qs_in;
         p_ds_ff <= p_ds_in;
         p_qc_ff <= p_qc_in;
         bus2_ff <= bus1_ff;
         alpha_ff <= ipsv_pkg::sat16(32'(diff_a));
         beta2_ff <= ipsv_pkg::sat16(32'(diff_b));
         bus3_ff <= bus2_ff;
         m_ff <= m_in;
         hb_ff <= beta2_ff >>> 1;
         beta3_ff <= beta2_ff;
         bus4_ff <= bus3_ff;
         u1_ff <= beta3_ff;
         u2_ff <= ipsv_pkg::trunc_q(x2);
         u3_ff <= ipsv_pkg::trunc_q(x3);
         bus5_ff <= bus4_ff;
         sec5_ff <= sec_in;
         lu_ff <= lu_in;
         bu_ff <= bu_in;
         bus6_ff <= bus5_ff;
         sec6_ff <= sec5_ff;
         la_ff <= 32'(lu_ff) * 32'(ipsv_pkg::Q_SQRT3);
         ba_ff <= 32'(bu_ff) * 32'(ipsv_pkg::Q_SQRT3);
         bus7_ff <= bus6_ff;
         sec7_ff <= sec6_ff;
         num7_ff[0] <= ln_in[47:14];
         num7_ff[1] <= bn_in[47:14];
      end
   end

   // vector times: divide by bus voltage
   ipsv_div_chain #(.NUM_W(34), .DIV_W(16), .TAG_W(SEC_W)) u_time_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v7_ff), .in_div(bus7_ff), .in_num(num7_ff), .in_tag(sec7_ff),
      .out_valid(c1_valid), .out_quo(c1_quo), .out_tag(c1_tag)
   );

   assign lq_sh = c1_quo[0] >> TIME_SCALE_SHIFT;
   assign bq_sh = c1_quo[1] >> TIME_SCALE_SHIFT;
   assign lead_in = (lq_sh > 34'd65535) ? 16'hFFFF : lq_sh[15:0];
   assign back_in = (bq_sh > 34'd65535) ? 16'hFFFF : bq_sh[15:0];
   assign sum_in = 17'(lead_in) + 17'(back_in);
   assign flag_in = sum_in > 17'(limit_ff);

   assign tag9_vec = tag9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lead8_ff <= lead_in;
         back8_ff <= back_in;
         sum8_ff <= sum_in;
         flag8_ff <= flag_in;
         sec8_ff <= ipsv_pkg::sector_type'(c1_tag);
         num9_ff[0] <= 32'(limit_ff) * 32'(lead8_ff);
         num9_ff[1] <= 32'(limit_ff) * 32'(back8_ff);
         div9_ff <= flag8_ff ? sum8_ff : 17'd1;
         tag9_ff.sector <= sec8_ff;
         tag9_ff.lead <= lead8_ff;
         tag9_ff.back <= back8_ff;
         tag9_ff.limited <= flag8_ff;
      end
   end

   // proportional scaling to the limit
   ipsv_div_chain #(.NUM_W(32), .DIV_W(17), .TAG_W(TAG2_W)) u_scale_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v9_ff), .in_div(div9_ff), .in_num(num9_ff), .in_tag(tag9_vec),
      .out_valid(c2_valid), .out_quo(c2_quo), .out_tag(c2_tag)
   );

   always_comb begin
      tag_out = ipsv_pkg::scale_tag_type'(c2_tag);
      lead_f = tag_out.limited ? c2_quo[0][15:0] : tag_out.lead;
      back_f = tag_out.limited ? c2_quo[1][15:0] : tag_out.back;
      p_s = 19'(period_ff);
      s_big = p_s - 19'(lead_f) - 19'(back_f);
      s_mid = p_s + 19'(lead_f) - 19'(back_f);
      s_small = p_s + 19'(lead_f) + 19'(back_f);
      case (tag_out.sector)
         ipsv_pkg::SEC_1: begin ca = s_big; cb = s_mid; cc = s_small; end
         ipsv_pkg::SEC_2: begin ca = s_mid; cb = s_big; cc = s_small; end
         ipsv_pkg::SEC_3: begin ca = s_small; cb = s_big; cc = s_mid; end
         ipsv_pkg::SEC_4: begin ca = s_small; cb = s_mid; cc = s_big; end
         ipsv_pkg::SEC_5: begin ca = s_mid; cb = s_small; cc = s_big; end
         ipsv_pkg::SEC_6: begin ca = s_big; cb = s_small; cc = s_mid; end
         default: begin ca = p_s; cb = p_s; cc = p_s; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmp_a_ff <= ipsv_pkg::compare_out(ca);
         cmp_b_ff <= ipsv_pkg::compare_out(cb);
         cmp_c_ff <= ipsv_pkg::compare_out(cc);
         sector_ff <= tag_out.sector;
         limited_ff <= tag_out.limited && (tag_out.sector != ipsv_pkg::SEC_NONE);
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.compare_a = cmp_a_ff;
   assign rsp_bus.compare_b = cmp_b_ff;
   assign rsp_bus.compare_c = cmp_c_ff;
   assign rsp_bus.sector = sector_ff;
   assign rsp_bus.limited = limited_ff;

   a_none_not_limited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sector_ff == ipsv_pkg::SEC_NONE |-> !limited_ff)
      else $error("limited set with undetermined sector");

   a_none_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sector_ff == ipsv_pkg::SEC_NONE
      |-> cmp_a_ff == cmp_b_ff && cmp_b_ff == cmp_c_ff)
      else $error("undetermined sector compares differ");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> cmp_a_ff != 16'd0 && cmp_b_ff != 16'd0 && cmp_c_ff != 16'd0)
      else $error("zero compare count");
endmodule

>>> test/inverse_park_svpwm_tb.sv
// Testbench for inverse_park_svpwm: directed table then random requests, each result
// checked in order against its table value or a predictor of the inverse Park / SVPWM math.
// Depends on ipsv_pkg, ipsv_req_if, ipsv_rsp_if and the block itself.
`timescale 1ns / 1ps
module inverse_park_svpwm_tb;

   localparam int LATENCY_WAIT = 100;
   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int NUM_PHASES = 8;

   typedef struct {
      logic signed [15:0] volt_d;
      logic signed [15:0] volt_q;
      logic signed [13:0] angle_sin;
      logic signed [13:0] angle_cos;
      logic [15:0] bus_voltage;
   } request_type;

   typedef struct {
      logic [15:0] compare_a;
      logic [15:0] compare_b;
      logic [15:0] compare_c;
      ipsv_pkg::sector_type sector;
      logic limited;
   } compare_set_type;

   typedef struct {
      request_type req;
      bit typed;
      compare_set_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   ipsv_req_if req_bus ();
   ipsv_rsp_if rsp_bus ();

   inverse_park_svpwm u_top (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   compare_set_type pending_compares[$];
   logic [15:0] period_shadow = ipsv_pkg::PERIOD_RESET;
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.volt_d = '0;
      req_bus.volt_q = '0;
      req_bus.angle_sin = '0;
      req_bus.angle_cos = '0;
      req_bus.bus_voltage = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic longint vector_time(input longint u, input longint bus,
                                          input longint period);
      longint t;
      if (u <= 0) begin
         return 0;
      end
      t = (28378 * u * period) / (bus << 14);
      return (t > 65535) ? 65535 : t;
   endfunction

   function automatic logic [15:0] half_clamp(input longint x);
      longint v;
      v = x >>> 1;
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      if (v == 0) begin
         v = 1;
      end
      return v[15:0];
   endfunction

   function automatic compare_set_type predict_compares(input request_type r,
                                                        input logic [15:0] period_reg);
      compare_set_type res;
      longint vd, vq, sn, cs, alpha, beta, hb, u1, u2, u3, lu, bu;
      longint bus, lead, back, total, lim, p, s_big, s_mid, s_small;
      int code;
      vd = r.volt_d;
      vq = r.volt_q;
      sn = r.angle_sin;
      cs = r.angle_cos;
      p = period_reg;
      alpha = (vd * cs - vq * sn) >>> 12;
      beta = (vd * sn + vq * cs) >>> 12;
      alpha = (alpha > 32767) ? 32767 : ((alpha < -32768) ? -32768 : alpha);
      beta = (beta > 32767) ? 32767 : ((beta < -32768) ? -32768 : beta);
      hb = beta >>> 1;
      u1 = beta;
      u2 = (14189 * alpha - hb * 16384) / 16384;
      u3 = (-14189 * alpha - hb * 16384) / 16384;
      code = (u1 > 0 ? 1 : 0) + (u2 > 0 ? 2 : 0) + (u3 > 0 ? 4 : 0);
      res.limited = 1'b0;
      case (code)
         ipsv_pkg::SIGN_U1: begin
            res.sector = ipsv_pkg::SEC_2; lu = -u2; bu = -u3;
         end
         ipsv_pkg::SIGN_U2: begin
            res.sector = ipsv_pkg::SEC_6; lu = -u3; bu = -u1;
         end
         ipsv_pkg::SIGN_U1U2: begin
            res.sector = ipsv_pkg::SEC_1; lu = u2; bu = u1;
         end
         ipsv_pkg::SIGN_U3: begin
            res.sector = ipsv_pkg::SEC_4; lu = -u1; bu = -u2;
         end
         ipsv_pkg::SIGN_U1U3: begin
            res.sector = ipsv_pkg::SEC_3; lu = u1; bu = u3;
         end
         ipsv_pkg::SIGN_U2U3: begin
            res.sector = ipsv_pkg::SEC_5; lu = u3; bu = u2;
         end
         default: begin
            res.sector = ipsv_pkg::SEC_NONE; lu = 0; bu = 0;
         end
      endcase
      bus = (r.bus_voltage == 0) ? 1 : r.bus_voltage;
      lead = vector_time(lu, bus, p);
      back = vector_time(bu, bus, p);
      total = lead + back;
      lim = (15728 * p) >> 14;
      if (total > lim) begin
         lead = lim * lead / total;
         back = lim * back / total;
         res.limited = 1'b1;
      end
      s_big = p - lead - back;
      s_mid = p + lead - back;
      s_small = p + lead + back;
      case (res.sector)
         ipsv_pkg::SEC_1: begin lu = s_big; bu = s_mid; lim = s_small; end
         ipsv_pkg::SEC_2: begin lu = s_mid; bu = s_big; lim = s_small; end
         ipsv_pkg::SEC_3: begin lu = s_small; bu = s_big; lim = s_mid; end
         ipsv_pkg::SEC_4: begin lu = s_small; bu = s_mid; lim = s_big; end
         ipsv_pkg::SEC_5: begin lu = s_mid; bu = s_small; lim = s_big; end
         ipsv_pkg::SEC_6: begin lu = s_big; bu = s_small; lim = s_mid; end
         default: begin lu = p; bu = p; lim = p; end
      endcase
      res.compare_a = half_clamp(lu);
      res.compare_b = half_clamp(bu);
      res.compare_c = half_clamp(lim);
      return res;
   endfunction

   // check results in arrival order
   always @(posedge clock) begin
      compare_set_type want;
      if (!reset) begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_compares.size() == 0) begin
               report("result with no request outstanding");
            end else begin
               want = pending_compares.pop_front();
               if (rsp_bus.compare_a !== want.compare_a)
                  report($sformatf("compare_a %0d want %0d", rsp_bus.compare_a,
                                   want.compare_a));
               if (rsp_bus.compare_b !== want.compare_b)
                  report($sformatf("compare_b %0d want %0d", rsp_bus.compare_b,
                                   want.compare_b));
               if (rsp_bus.compare_c !== want.compare_c)
                  report($sformatf("compare_c %0d want %0d", rsp_bus.compare_c,
                                   want.compare_c));
               if (rsp_bus.sector !== want.sector)
                  report($sformatf("sector %0d want %0d", rsp_bus.sector, want.sector));
               if (rsp_bus.limited !== want.limited)
                  report($sformatf("limited %0b want %0b", rsp_bus.limited,
                                   want.limited));
            end
         end
      end
   end

   task automatic send_request(input request_type r, input bit typed,
                               input compare_set_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.volt_d <= r.volt_d;
      req_bus.volt_q <= r.volt_q;
      req_bus.angle_sin <= r.angle_sin;
      req_bus.angle_cos <= r.angle_cos;
      req_bus.bus_voltage <= r.bus_voltage;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      pending_compares.push_back(typed ? want : predict_compares(r, period_shadow));
   endtask

   task automatic write_period(input logic [15:0] value);
      req_bus.valid <= 1'b0;
      wait (pending_compares.size() == 0);
      repeat (LATENCY_WAIT) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * ipsv_pkg::CSR_PERIOD_INDEX);
      pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== value) begin
         report($sformatf("period reads %0d want %0d", prdata[15:0], value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      period_shadow = value;
   endtask

   function automatic request_type random_request();
      request_type r;
      real th;
      int amp;
      if ($urandom_range(99) < 70) begin
         th = $urandom_range(0, 62831) / 10000.0;
         r.angle_sin = 14'($rtoi(4096.0 * $sin(th)));
         r.angle_cos = 14'($rtoi(4096.0 * $cos(th)));
      end else begin
         r.angle_sin = 14'($signed($urandom_range(0, 8192)) - 4096);
         r.angle_cos = 14'($signed($urandom_range(0, 8192)) - 4096);
      end
      amp = 1 << $urandom_range(4, 16);
      r.volt_d = 16'($signed($urandom_range(0, amp - 1)) - amp / 2);
      r.volt_q = 16'($signed($urandom_range(0, amp - 1)) - amp / 2);
      r.bus_voltage = ($urandom_range(9) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, amp * 2));
      return r;
   endfunction

   stim_row_type stim_table[$];

   function automatic stim_row_type row(input int vd, input int vq, input int sn,
                                        input int cs, input int bus, input bit typed,
                                        input int cmp, input ipsv_pkg::sector_type sec);
      stim_row_type s;
      s.req.volt_d = 16'(vd);
      s.req.volt_q = 16'(vq);
      s.req.angle_sin = 14'(sn);
      s.req.angle_cos = 14'(cs);
      s.req.bus_voltage = 16'(bus);
      s.typed = typed;
      s.want.compare_a = 16'(cmp);
      s.want.compare_b = 16'(cmp);
      s.want.compare_c = 16'(cmp);
      s.want.sector = sec;
      s.want.limited = 1'b0;
      return s;
   endfunction

   initial begin
      compare_set_type none;
      request_type r;
      logic [15:0] periods[NUM_PHASES];
      none.compare_a = 16'd0;
      none.compare_b = 16'd0;
      none.compare_c = 16'd0;
      none.sector = ipsv_pkg::SEC_NONE;
      none.limited = 1'b0;
      periods = '{16'd3600, 16'd65535, 16'd1, 16'd0, 16'd1000, 16'd20000, 16'd2, 16'd3600};
      // at reset period, a zero vector gives half duty, with a nonzero and with a zero bus
      stim_table.push_back(row(0, 0, 0, 4096, 1000, 1, 1800, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(0, 0, 0, 0, 0, 1, 1800, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(32767, 0, 0, 4096, 1, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(-32768, 0, 0, 4096, 1, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(0, 32767, -4096, 4096, 65535, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(-32768, -32768, -4096, -4096, 65535, 0, 0,
                               ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(32767, 32767, 4096, 4096, 0, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(-1, -1, 4096, -4096, 65535, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, 2048, 3547, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, 4096, 0, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, 2048, -3547, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, -2048, -3547, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, -4096, 0, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(1000, 0, -2048, 3547, 20000, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(20000, 0, 2048, 3547, 100, 0, 0, ipsv_pkg::SEC_NONE));
      stim_table.push_back(row(5461, -10923, 1365, 8191, 21845, 0, 0, ipsv_pkg::SEC_NONE));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_table[i]) begin
         send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
      end
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_period(periods[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 49; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 49; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = random_request();
            send_request(r, 1'b0, none);
         end
      end
      req_bus.valid <= 1'b0;
      wait (pending_compares.size() == 0);
      repeat (LATENCY_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
